/* rtl/gfra_pkg.sv */
// Constants and types for the GB2312 font ROM address decoder.
`default_nettype none

package gfra_pkg;

   localparam int unsigned TextWidth    = 8;
   localparam int unsigned CoordWidth   = 16;
   localparam int unsigned AddrWidth    = 18;
   localparam int unsigned GlyphIdWidth = 13;

   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 56;

   localparam logic [TextWidth-1:0] HanziLo  = 8'hB0;
   localparam logic [TextWidth-1:0] HanziHi  = 8'hF7;
   localparam logic [TextWidth-1:0] SymLo    = 8'hA1;
   localparam logic [TextWidth-1:0] SymHi    = 8'hA3;
   localparam logic [TextWidth-1:0] TrailMin = 8'hA1;
   localparam logic [TextWidth-1:0] AsciiLo  = 8'h20;
   localparam logic [TextWidth-1:0] AsciiHi  = 8'h7E;

   localparam logic [GlyphIdWidth-1:0] RowLen      = 13'd94;
   localparam logic [GlyphIdWidth-1:0] HanziOffset = 13'd846;
   localparam logic [AddrWidth-1:0]    AsciiBase   = 18'h3B7C0;

   localparam logic [CoordWidth-1:0] WideAdvance   = 16'd16;
   localparam logic [CoordWidth-1:0] NarrowAdvance = 16'd8;

   // 16x16 glyph is 32 bytes, 8x16 glyph is 16 bytes
   localparam int unsigned WideShift   = 5;
   localparam int unsigned NarrowShift = 4;

   typedef struct packed {
      logic [CoordWidth-1:0] start_y;
      logic [CoordWidth-1:0] start_x;
      logic [TextWidth-1:0]  text_byte;
   } req_data_type;

   typedef struct packed {
      logic [RspDataWidth-AddrWidth-2*CoordWidth-1:0] pad;
      logic [CoordWidth-1:0]                          row;
      logic [CoordWidth-1:0]                          column;
      logic [AddrWidth-1:0]                           rom_address;
   } rsp_data_type;

endpackage

`default_nettype wire

/* rtl/gb2312_font_rom_addresser_unit.sv */
// Top level: GB2312 / ASCII byte stream to font ROM glyph fetch requests.
`default_nettype none

// Channel  Dir  Ports                     Item
// req      in   req_tvalid/tready/tdata   one text byte with start flag and origin
// rsp      out  rsp_tvalid/tready/tdata   one glyph fetch: address, column, row
//
// One item is accepted per cycle while req_tready is high; a byte passes the input register and then the
// result register, and any result it yields is offered from the result register.
// Decode and cursor update sit in the single logic level between the two registers.
// A stalled result holds the result register, and the input register then holds its
// byte too, whether or not that byte yields a result; req_tready stays high while the
// input register is empty or hands its byte on in that cycle.
// Reset (synchronous) clears both valid flags, the pending lead and the cursor.

module gb2312_font_rom_addresser_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // text_byte[7:0], start_x[23:8], start_y[39:24]
   input  wire  [gfra_pkg::ReqDataWidth-1:0] req_tdata,
   // string_start
   input  wire                          req_tuser,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // rom_address[17:0], column[33:18], row[49:34], zeros above
   output logic [gfra_pkg::RspDataWidth-1:0] rsp_tdata,
   // glyph_wide
   output logic                         rsp_tuser
);

   import gfra_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_data_type in_data_ff;
   logic         in_start_ff;

   // decode state
   logic                  lead_pending_ff, lead_pending_in;
   logic [TextWidth-1:0]  lead_byte_ff, lead_byte_in;
   logic [CoordWidth-1:0] cursor_column_ff, cursor_column_in;
   logic [CoordWidth-1:0] cursor_row_ff, cursor_row_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [AddrWidth-1:0]  out_address_ff, out_address_in;
   logic                  out_wide_ff, out_wide_in;
   logic [CoordWidth-1:0] out_column_ff, out_column_in;
   logic [CoordWidth-1:0] out_row_ff;

   logic                    advance;
   logic                    take_req;
   logic                    pend;
   logic [CoordWidth-1:0]   col_now;
   logic [TextWidth-1:0]    cur_byte;
   logic                    byte_is_lead;
   logic                    byte_is_ascii;
   logic                    make_pair;
   logic [TextWidth-1:0]    lead_base;
   logic [GlyphIdWidth-1:0] lead_index;
   logic [GlyphIdWidth-1:0] glyph_id;
   logic [AddrWidth-1:0]    wide_address;
   logic [AddrWidth-1:0]    narrow_address;
   rsp_data_type            rsp_pack;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   // start of a string overrides the pending lead and the cursor
   assign cur_byte = in_data_ff.text_byte;
   assign pend     = in_start_ff ? 1'b0 : lead_pending_ff;
   assign col_now  = in_start_ff ? in_data_ff.start_x : cursor_column_ff;

   assign byte_is_lead  = ((cur_byte >= HanziLo) && (cur_byte <= HanziHi))
                       || ((cur_byte >= SymLo) && (cur_byte <= SymHi));
   assign byte_is_ascii = (cur_byte >= AsciiLo) && (cur_byte <= AsciiHi);
   assign make_pair     = pend && (cur_byte >= TrailMin);

   // glyph index from lead row and trail cell; hanzi rows follow the symbol block
   assign lead_base  = (lead_byte_ff >= HanziLo) ? HanziLo : SymLo;
   assign lead_index = GlyphIdWidth'(lead_byte_ff - lead_base) * RowLen;
   assign glyph_id   = lead_index + GlyphIdWidth'(cur_byte - TrailMin)
                     + ((lead_byte_ff >= HanziLo) ? HanziOffset : '0);

   assign wide_address   = AddrWidth'(glyph_id) << WideShift;
   assign narrow_address = (AddrWidth'(cur_byte - AsciiLo) << NarrowShift) + AsciiBase;

   always_comb begin
      lead_pending_in  = lead_pending_ff;
      lead_byte_in     = lead_byte_ff;
      cursor_column_in = cursor_column_ff;
      cursor_row_in    = cursor_row_ff;
      out_address_in   = out_address_ff;
      out_wide_in      = out_wide_ff;
      out_column_in    = out_column_ff;
      out_valid_in     = out_valid_ff && !rsp_tready;
      if (advance) begin
         cursor_row_in    = in_start_ff ? in_data_ff.start_y : cursor_row_ff;
         cursor_column_in = col_now;
         lead_pending_in  = 1'b0;
         out_column_in    = col_now;
         priority if (make_pair) begin
            out_valid_in     = 1'b1;
            out_address_in   = wide_address;
            out_wide_in      = 1'b1;
            cursor_column_in = col_now + WideAdvance;
         end else if (byte_is_lead) begin
            lead_pending_in = 1'b1;
            lead_byte_in    = cur_byte;
         end else if (byte_is_ascii) begin
            out_valid_in     = 1'b1;
            out_address_in   = narrow_address;
            out_wide_in      = 1'b0;
            cursor_column_in = col_now + NarrowAdvance;
         end else begin
            // drop: terminator, stray byte or a lead with no valid trail
            lead_pending_in = 1'b0;
         end
      end
   end

   assign in_valid_in = take_req ? 1'b1 : (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         lead_pending_ff  <= 1'b0;
         lead_byte_ff     <= '0;
         cursor_column_ff <= '0;
         cursor_row_ff    <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         lead_pending_ff  <= lead_pending_in;
         lead_byte_ff     <= lead_byte_in;
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff  <= req_data_type'(req_tdata);
         in_start_ff <= req_tuser;
      end
      if (advance) begin
         out_row_ff <= in_start_ff ? in_data_ff.start_y : cursor_row_ff;
      end
      out_address_ff <= out_address_in;
      out_wide_ff    <= out_wide_in;
      out_column_ff  <= out_column_in;
   end

   always_comb begin
      rsp_pack             = '0;
      rsp_pack.rom_address = out_address_ff;
      rsp_pack.column      = out_column_ff;
      rsp_pack.row         = out_row_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_pack;
   assign rsp_tuser  = out_wide_ff;

endmodule

`default_nettype wire
